@@ rtl/ntf_pkg.sv @@
package ntf_pkg;

  // Offset register file
  localparam int NUM_OFFSET_REGS = 6;
  localparam int ADDR_W          = 5;

  localparam logic [2:0] REG_C_CSHARP     = 3'd0;
  localparam logic [2:0] REG_D_DSHARP     = 3'd1;
  localparam logic [2:0] REG_E_F          = 3'd2;
  localparam logic [2:0] REG_FSHARP_G     = 3'd3;
  localparam logic [2:0] REG_GSHARP_A     = 3'd4;
  localparam logic [2:0] REG_ASHARP_B     = 3'd5;

  // Pitch arithmetic in eighth-cents
  localparam int EIGHTHS_PER_OCTAVE   = 9600;
  localparam int EIGHTHS_PER_SEMITONE = 800;
  localparam int REF_NOTE             = 69;
  localparam int OCT_BIAS             = 8;
  localparam int PITCH_BIAS           = OCT_BIAS * EIGHTHS_PER_OCTAVE
                                        - REF_NOTE * EIGHTHS_PER_SEMITONE;
  localparam logic signed [14:0] OFFSET_LIMIT = 15'sd9600;

  // floor(2^32 / 9600); exact floor after one correction step
  localparam int OCT_RECIP_W = 19;
  localparam int OCT_RECIP   = 447392;

  // Rounded divide by 9600 done as >>7 then /75
  localparam int HALF_OCTAVE   = EIGHTHS_PER_OCTAVE / 2;
  localparam int DIV_POW2      = 7;
  localparam int DIV_ODD       = 75;
  localparam int DIV_ODD_SHIFT = 35;
  localparam int DIV_ODD_RECIP = 458129844;   // floor(2^35 / 75)

  // Output scaling
  localparam int BASE_HZ    = 440;
  localparam int SHIFT_BASE = 15 + OCT_BIAS;

  // Field widths
  localparam int NOTE_W = 7;
  localparam int OCT_W  = 4;
  localparam int FRAC_W = 14;
  localparam int Q_W    = 18;
  localparam int MANT_W = 33;
  // Largest table step is at N = 16, about 1.8e8, so 28 bits cover every N >= 16
  localparam int DIFF_W = 28;
  localparam int X_W    = 35;
  localparam int HZ_W   = 42;
  localparam int FREQ_W = 32;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  typedef logic [NUM_OFFSET_REGS-1:0][31:0] offs_regs_t;

  typedef struct packed {
    logic [OCT_W-1:0]  oct;
    logic [FRAC_W-1:0] frac;
  } oct_frac_t;

  typedef struct packed {
    logic [OCT_W-1:0]  oct;
    logic [MANT_W-1:0] lo;
    logic [DIFF_W-1:0] quo;
  } mant_parts_t;

  // 2^(f / 2^32) in Q31 by a Taylor sum of e^(f * ln2); f is a Q32 fraction
  function automatic logic [MANT_W-1:0] exp2_q31(input logic [63:0] f);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = (f * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= 30; k++) begin
      if (term != 64'd0) begin
        term = ((term * y) >> 32) / 64'(k);
        sum  = sum + term;
      end
    end
    return MANT_W'((sum + 64'd1) >> 1);
  endfunction

endpackage

@@ rtl/ntf_cfg.sv @@
module ntf_cfg import ntf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output offs_regs_t        offs
);

  offs_regs_t offs_r;
  logic [2:0] reg_idx;
  logic       wr_fire;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_fire = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign offs    = offs_r;

  // Register writes; addresses past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offs_r <= '0;
    end else if (wr_fire) begin
      case (reg_idx)
        REG_C_CSHARP, REG_D_DSHARP, REG_E_F,
        REG_FSHARP_G, REG_GSHARP_A, REG_ASHARP_B: begin
          offs_r[reg_idx] <= pwdata;
        end
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (reg_idx)
      REG_C_CSHARP, REG_D_DSHARP, REG_E_F,
      REG_FSHARP_G, REG_GSHARP_A, REG_ASHARP_B: begin
        prdata = offs_r[reg_idx];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

@@ rtl/ntf_pitch.sv @@
module ntf_pitch import ntf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [NOTE_W-1:0] note,
  input  offs_regs_t        offs,
  output logic              dn_valid,
  input  logic              dn_ready,
  output oct_frac_t         dn_data
);

  localparam int NS = 4;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  // Stage 1: pitch class, lane pick, clamp
  logic [14:0]             div12_prod;
  logic [3:0]              div12;
  logic [NOTE_W-1:0]       pclass;
  logic [31:0]             reg_sel;
  logic signed [15:0]      lane;
  logic signed [14:0]      off_c;
  logic [NOTE_W-1:0]       s1_note_r;
  logic signed [14:0]      s1_off_r;

  // Stage 2: pitch with octave bias
  logic [16:0]             note_mul;
  logic [Q_W:0]            q_sum;
  logic [Q_W-1:0]          s2_q_r;

  // Stage 3: octave estimate
  logic [Q_W+OCT_RECIP_W-1:0] oct_prod;
  logic [Q_W-1:0]          s3_q_r;
  logic [OCT_W-1:0]        s3_est_r;

  // Stage 4: correction
  logic [Q_W-1:0]          rem;
  oct_frac_t               s4_nxt;
  oct_frac_t               s4_r;

  // Bubble-collapsing enables
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[NS-1];
  assign dn_data  = s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // note / 12 as (note * 171) >> 11, exact for 7-bit notes
  always_comb begin
    div12_prod = 15'(note) * 15'd171;
    div12      = div12_prod[14:11];
    pclass     = note - NOTE_W'(7'(div12) * 7'd12);
    reg_sel    = offs[pclass[3:1]];
    lane       = pclass[0] ? signed'(reg_sel[31:16]) : signed'(reg_sel[15:0]);
    if (lane > 16'(OFFSET_LIMIT)) begin
      off_c = OFFSET_LIMIT;
    end else if (lane < -16'(OFFSET_LIMIT)) begin
      off_c = -OFFSET_LIMIT;
    end else begin
      off_c = lane[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_note_r <= note;
      s1_off_r  <= off_c;
    end
  end

  // Biased pitch is always positive and below 2^18
  always_comb begin
    note_mul = 17'(s1_note_r) * 17'(EIGHTHS_PER_SEMITONE);
    q_sum    = (Q_W+1)'(note_mul) + (Q_W+1)'(s1_off_r) + (Q_W+1)'(PITCH_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_q_r <= q_sum[Q_W-1:0];
    end
  end

  // Reciprocal estimate, at most one low
  assign oct_prod = (Q_W+OCT_RECIP_W)'(s2_q_r) * (Q_W+OCT_RECIP_W)'(OCT_RECIP);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_q_r   <= s2_q_r;
      s3_est_r <= oct_prod[32 +: OCT_W];
    end
  end

  always_comb begin
    rem = s3_q_r - Q_W'(Q_W'(s3_est_r) * Q_W'(EIGHTHS_PER_OCTAVE));
    if (rem >= Q_W'(EIGHTHS_PER_OCTAVE)) begin
      s4_nxt.oct  = s3_est_r + OCT_W'(1);
      s4_nxt.frac = FRAC_W'(rem - Q_W'(EIGHTHS_PER_OCTAVE));
    end else begin
      s4_nxt.oct  = s3_est_r;
      s4_nxt.frac = FRAC_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_r <= s4_nxt;
    end
  end

endmodule

@@ rtl/ntf_interp.sv @@
module ntf_interp import ntf_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  oct_frac_t   up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output mant_parts_t dn_data
);

  localparam int NS     = 9;
  localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES);
  localparam int TBL_AW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int T_W    = $clog2(EIGHTHS_PER_OCTAVE * EXP_TABLE_ENTRIES);
  localparam int P_W    = T_W + OCT_RECIP_W;
  localparam int PR_W   = DIFF_W + FRAC_W + 1;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  // exp2 table, 2^(i/N) in Q31, built at elaboration
  logic [MANT_W-1:0] exp_tbl [EXP_TABLE_ENTRIES+1];

  for (genvar i = 0; i <= EXP_TABLE_ENTRIES; i++) begin : g_tbl
    localparam logic [63:0] FRAC_Q32 = (64'(i) << 32) / 64'(EXP_TABLE_ENTRIES);
    assign exp_tbl[i] = exp2_q31(FRAC_Q32);
  end

  logic [OCT_W-1:0]  oct_r [NS-1];
  logic [T_W-1:0]    s5_t_r;
  logic [P_W-1:0]    idx_prod;
  logic [T_W-1:0]    s6_t_r;
  logic [IDX_W-1:0]  s6_est_r;
  logic [T_W-1:0]    t_rem;
  logic [IDX_W-1:0]  idx_nxt;
  logic [FRAC_W-1:0] r_nxt;
  logic [IDX_W-1:0]  s7_idx_r;
  logic [FRAC_W-1:0] s7_r_r;
  logic [TBL_AW-1:0] lo_addr;
  logic [TBL_AW-1:0] hi_addr;
  logic [MANT_W-1:0] s8_lo_r;
  logic [MANT_W-1:0] s8_hi_r;
  logic [FRAC_W-1:0] s8_r_r;
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] s9_diff_r;
  logic [MANT_W-1:0] s9_lo_r;
  logic [FRAC_W-1:0] s9_r_r;
  logic [PR_W-1:0]   wprod;
  logic [X_W-1:0]    s10_x_r;
  logic [MANT_W-1:0] s10_lo_r;
  logic [46:0]       pph;
  logic [45:0]       ppl;
  logic [46:0]       s11_pph_r;
  logic [45:0]       s11_ppl_r;
  logic [X_W-1:0]    s11_x_r;
  logic [MANT_W-1:0] s11_lo_r;
  logic [63:0]       pp_sum;
  logic [DIFF_W-1:0] s12_est_r;
  logic [X_W-1:0]    s12_x_r;
  logic [MANT_W-1:0] s12_lo_r;
  logic [X_W-1:0]    x_rem;
  mant_parts_t       s13_nxt;
  mant_parts_t       s13_r;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[NS-1];
  assign dn_data  = s13_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Octave rides along with each stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      oct_r[0] <= up_data.oct;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        oct_r[k] <= oct_r[k-1];
      end
    end
  end

  // Scale fraction to table units
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s5_t_r <= T_W'(up_data.frac) * T_W'(EXP_TABLE_ENTRIES);
    end
  end

  // Table index estimate
  assign idx_prod = P_W'(s5_t_r) * P_W'(OCT_RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s6_t_r   <= s5_t_r;
      s6_est_r <= idx_prod[32 +: IDX_W];
    end
  end

  // Index correction and remainder
  always_comb begin
    t_rem = s6_t_r - T_W'(T_W'(s6_est_r) * T_W'(EIGHTHS_PER_OCTAVE));
    if (t_rem >= T_W'(EIGHTHS_PER_OCTAVE)) begin
      idx_nxt = s6_est_r + IDX_W'(1);
      r_nxt   = FRAC_W'(t_rem - T_W'(EIGHTHS_PER_OCTAVE));
    end else begin
      idx_nxt = s6_est_r;
      r_nxt   = FRAC_W'(t_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s7_idx_r <= idx_nxt;
      s7_r_r   <= r_nxt;
    end
  end

  // Table lookup, registered
  assign lo_addr = TBL_AW'(s7_idx_r);
  assign hi_addr = lo_addr + TBL_AW'(1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s8_lo_r <= exp_tbl[lo_addr];
      s8_hi_r <= exp_tbl[hi_addr];
      s8_r_r  <= s7_r_r;
    end
  end

  // Segment step
  assign diff = (s8_hi_r > s8_lo_r) ? DIFF_W'(s8_hi_r - s8_lo_r) : '0;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s9_diff_r <= diff;
      s9_lo_r   <= s8_lo_r;
      s9_r_r    <= s8_r_r;
    end
  end

  // Weighted step plus half, then drop the power-of-two part of 9600
  assign wprod = PR_W'(s9_diff_r) * PR_W'(s9_r_r) + PR_W'(HALF_OCTAVE);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s10_x_r  <= X_W'(wprod >> DIV_POW2);
      s10_lo_r <= s9_lo_r;
    end
  end

  // Divide by 75: two partial products of the reciprocal
  assign pph = 47'(s10_x_r[X_W-1:17]) * 47'(DIV_ODD_RECIP);
  assign ppl = 46'(s10_x_r[16:0]) * 46'(DIV_ODD_RECIP);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s11_pph_r <= pph;
      s11_ppl_r <= ppl;
      s11_x_r   <= s10_x_r;
      s11_lo_r  <= s10_lo_r;
    end
  end

  assign pp_sum = (64'(s11_pph_r) << 17) + 64'(s11_ppl_r);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s12_est_r <= pp_sum[DIV_ODD_SHIFT +: DIFF_W];
      s12_x_r   <= s11_x_r;
      s12_lo_r  <= s11_lo_r;
    end
  end

  // Quotient correction
  always_comb begin
    x_rem       = s12_x_r - X_W'(X_W'(s12_est_r) * X_W'(DIV_ODD));
    s13_nxt.oct = oct_r[NS-2];
    s13_nxt.lo  = s12_lo_r;
    if (x_rem >= X_W'(DIV_ODD)) begin
      s13_nxt.quo = s12_est_r + DIFF_W'(1);
    end else begin
      s13_nxt.quo = s12_est_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s13_r <= s13_nxt;
    end
  end

endmodule

@@ rtl/ntf_scale.sv @@
module ntf_scale import ntf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  mant_parts_t       up_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FREQ_W-1:0] out_frequency_q16
);

  localparam int NS = 3;

  logic [NS-1:0]     vld_r;
  logic [NS-1:0]     en;
  logic [MANT_W-1:0] s14_m_r;
  logic [OCT_W-1:0]  s14_oct_r;
  logic [HZ_W-1:0]   s15_hz_r;
  logic [OCT_W-1:0]  s15_oct_r;
  logic [4:0]        shamt;
  logic [HZ_W:0]     rounded;
  logic [FREQ_W-1:0] freq_nxt;
  logic [FREQ_W-1:0] freq_r;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign up_ready          = en[0];
  assign out_valid         = vld_r[NS-1];
  assign out_frequency_q16 = freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Interpolated mantissa
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s14_m_r   <= up_data.lo + MANT_W'(up_data.quo);
      s14_oct_r <= up_data.oct;
    end
  end

  // Times 440 Hz
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s15_hz_r  <= HZ_W'(s14_m_r) * HZ_W'(BASE_HZ);
      s15_oct_r <= s14_oct_r;
    end
  end

  // Octave shift with round half up, saturate to 32 bits
  always_comb begin
    shamt    = 5'(SHIFT_BASE) - 5'(s15_oct_r);
    rounded  = ((HZ_W+1)'(s15_hz_r) + ((HZ_W+1)'(1) << (shamt - 5'd1))) >> shamt;
    freq_nxt = (|rounded[HZ_W:FREQ_W]) ? '1 : rounded[FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      freq_r <= freq_nxt;
    end
  end

endmodule

@@ rtl/note_to_frequency_microtuned.sv @@
// MIDI note to frequency, 12-TET with A4 = 440 Hz at note 69, plus a signed
// per-pitch-class offset in eighth-cents (clamped to +-1200 cents) from six
// APB registers, two 16-bit lanes each, even class in the low lane. Output is
// unsigned Q16.16 Hz. One note transfer per cycle sustained while the output is
// not stalled. The pipeline depth comes from two reciprocal divides by 9600
// (octave split, table index), the registered exp2 table read, and a two-part
// reciprocal divide for the rounded interpolation. Stages with no item fill
// while the output waits, so in_stall only rises once every stage holds an
// item. The exp2 table has EXP_TABLE_ENTRIES + 1 constant entries; no clearing
// pass after reset.
module note_to_frequency_microtuned import ntf_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [NOTE_W-1:0] in_note_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FREQ_W-1:0] out_frequency_q16,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  offs_regs_t  offs;
  logic        in_ready;
  logic        pitch_valid;
  logic        pitch_ready;
  oct_frac_t   pitch_data;
  logic        mant_valid;
  logic        mant_ready;
  mant_parts_t mant_data;

  assign in_stall = !in_ready;

  ntf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .offs    (offs)
  );

  ntf_pitch u_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .note     (in_note_number),
    .offs     (offs),
    .dn_valid (pitch_valid),
    .dn_ready (pitch_ready),
    .dn_data  (pitch_data)
  );

  ntf_interp #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pitch_valid),
    .up_ready (pitch_ready),
    .up_data  (pitch_data),
    .dn_valid (mant_valid),
    .dn_ready (mant_ready),
    .dn_data  (mant_data)
  );

  ntf_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (mant_valid),
    .up_ready          (mant_ready),
    .up_data           (mant_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frequency_q16 (out_frequency_q16)
  );

  // An empty output register means the whole pipe can move
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A register write lands in the addressed lane pair
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[ADDR_W-1:2] <= REG_ASHARP_B)
    |=> offs[$past(paddr[ADDR_W-1:2])] == $past(pwdata))
    else $error("offset register write lost");

  // Octave split is fully corrected: biased octave 1..13, fraction in range
  a_oct_split: assert property (@(posedge clk) disable iff (!rst_n)
    pitch_valid |-> (pitch_data.oct >= OCT_W'(1) && pitch_data.oct <= OCT_W'(13)
                     && pitch_data.frac < FRAC_W'(EIGHTHS_PER_OCTAVE)))
    else $error("octave split out of range");

  // Offsets are clamped, so the result never reaches saturation
  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frequency_q16 != '1)
    else $error("frequency saturated");

endmodule
